FILE: sv/tass_pkg.sv
// Package for the three-axis step sequencer: widths, item kind codes and
// the input and result payload types. No dependencies.
`default_nettype none
package tass_pkg;

    localparam int STEP_COUNT_BITS = 20;
    localparam int DELAY_BITS      = 16;
    localparam int POSITION_BITS   = 32;
    localparam int NUM_AXES        = 3;
    localparam int AXIS_W          = 2;
    localparam int KIND_W          = 2;

    // Axis codes; AXIS_NONE marks "no axis due"
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_ESTOP = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    typedef logic [STEP_COUNT_BITS-1:0] t_count;
    typedef logic [DELAY_BITS-1:0]      t_delay;
    typedef logic [POSITION_BITS-1:0]   t_pos;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [STEP_COUNT_BITS-1:0] steps_x;
        logic [STEP_COUNT_BITS-1:0] steps_y;
        logic [STEP_COUNT_BITS-1:0] steps_z;
        logic [NUM_AXES-1:0]        dir_mask;
        logic [DELAY_BITS-1:0]      delay_x;
        logic [DELAY_BITS-1:0]      delay_y;
        logic [DELAY_BITS-1:0]      delay_z;
        logic [NUM_AXES-1:0]        endstop_mask;
    } t_in_item;

    typedef struct packed {
        logic [NUM_AXES-1:0]             step_mask;
        logic [NUM_AXES-1:0]             dir_out;
        logic                            busy_res;
        logic                            aborted;
        logic                            enabled;
        logic signed [POSITION_BITS-1:0] pos_x;
        logic signed [POSITION_BITS-1:0] pos_y;
        logic signed [POSITION_BITS-1:0] pos_z;
    } t_out_item;

endpackage
`default_nettype wire

FILE: sv/tass_in_if.sv
// Input channel of the step sequencer: valid/ready plus one input item.
// Depends on tass_pkg.
`default_nettype none
interface tass_in_if;
    logic               valid;
    logic               ready;
    tass_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/tass_out_if.sv
// Result channel of the step sequencer: valid/ready plus one result item.
// Depends on tass_pkg.
`default_nettype none
interface tass_out_if;
    logic                valid;
    logic                ready;
    tass_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/tass_core.sv
// Move state of the step sequencer and its update for one item.
// Produces the result item combinationally from state and item. Depends on tass_pkg.
`default_nettype none
module tass_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire tass_pkg::t_in_item  i_item,
    output tass_pkg::t_out_item      o_result
);

    localparam int NA = tass_pkg::NUM_AXES;
    localparam int SB = tass_pkg::STEP_COUNT_BITS;
    localparam int DB = tass_pkg::DELAY_BITS;
    localparam int PB = tass_pkg::POSITION_BITS;
    localparam int AW = tass_pkg::AXIS_W;

    logic                 r_active, n_active;
    logic [SB-1:0]        r_round, n_round;
    logic [AW-1:0]        r_phase, n_phase;
    logic [DB-1:0]        r_wait, n_wait;
    tass_pkg::t_count     r_counts [NA];
    tass_pkg::t_count     n_counts [NA];
    tass_pkg::t_delay     r_delays [NA];
    tass_pkg::t_delay     n_delays [NA];
    logic [NA-1:0]        r_dir, n_dir;
    tass_pkg::t_pos       r_pos [NA];
    tass_pkg::t_pos       n_pos [NA];
    logic                 r_abort, n_abort;
    logic                 r_enable, n_enable;

    logic [SB:0]          round_cur;
    logic [SB:0]          round_nxt;
    logic [NA-1:0]        due_cur;
    logic [NA-1:0]        due_nxt;
    logic [AW-1:0]        ax_cur;
    logic [AW-1:0]        ax_nxt;
    logic [AW-1:0]        ax;
    logic [SB:0]          round_use;
    logic [NA-1:0]        pulse;
    tass_pkg::t_count     start_counts [NA];
    tass_pkg::t_delay     start_delays [NA];
    tass_pkg::t_delay     ax_delay;
    tass_pkg::t_pos       ax_pos_step;

    assign start_counts[0] = i_item.steps_x;
    assign start_counts[1] = i_item.steps_y;
    assign start_counts[2] = i_item.steps_z;
    assign start_delays[0] = i_item.delay_x;
    assign start_delays[1] = i_item.delay_y;
    assign start_delays[2] = i_item.delay_z;

    // Due flags for this round and the next one, then the first due axis
    assign round_cur = {1'b0, r_round};
    assign round_nxt = round_cur + {{SB{1'b0}}, 1'b1};

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            due_cur[a] = ({1'b0, r_counts[a]} > round_cur) && (AW'(a) >= r_phase);
            due_nxt[a] = ({1'b0, r_counts[a]} > round_nxt);
        end
    end

    always_comb begin
        ax_cur = tass_pkg::AXIS_NONE;
        ax_nxt = tass_pkg::AXIS_NONE;
        for (int a = NA - 1; a >= 0; a--) begin
            if (due_cur[a]) begin
                ax_cur = AW'(a);
            end
            if (due_nxt[a]) begin
                ax_nxt = AW'(a);
            end
        end
    end

    // Current round exhausted: move on to the next round
    assign ax        = (ax_cur != tass_pkg::AXIS_NONE) ? ax_cur : ax_nxt;
    assign round_use = (ax_cur != tass_pkg::AXIS_NONE) ? round_cur : round_nxt;

    // Delay and stepped position of the due axis
    always_comb begin
        case (ax)
            tass_pkg::AXIS_X: begin
                ax_delay    = r_delays[0];
                ax_pos_step = r_dir[0] ? r_pos[0] + PB'(1) : r_pos[0] - PB'(1);
            end
            tass_pkg::AXIS_Y: begin
                ax_delay    = r_delays[1];
                ax_pos_step = r_dir[1] ? r_pos[1] + PB'(1) : r_pos[1] - PB'(1);
            end
            tass_pkg::AXIS_Z: begin
                ax_delay    = r_delays[2];
                ax_pos_step = r_dir[2] ? r_pos[2] + PB'(1) : r_pos[2] - PB'(1);
            end
            default: begin
                ax_delay    = '0;
                ax_pos_step = '0;
            end
        endcase
    end

    always_comb begin
        n_active = r_active;
        n_round  = r_round;
        n_phase  = r_phase;
        n_wait   = r_wait;
        n_dir    = r_dir;
        n_abort  = r_abort;
        n_enable = r_enable;
        pulse    = '0;
        for (int a = 0; a < NA; a++) begin
            n_counts[a] = r_counts[a];
            n_delays[a] = r_delays[a];
            n_pos[a]    = r_pos[a];
        end

        case (tass_pkg::t_kind'(i_item.kind))
            tass_pkg::KIND_START: begin
                if (!r_active) begin
                    for (int a = 0; a < NA; a++) begin
                        n_counts[a] = start_counts[a];
                        n_delays[a] = start_delays[a];
                    end
                    n_dir    = i_item.dir_mask;
                    n_round  = '0;
                    n_phase  = tass_pkg::AXIS_X;
                    n_wait   = '0;
                    n_abort  = 1'b0;
                    n_active = (i_item.steps_x != '0) || (i_item.steps_y != '0)
                            || (i_item.steps_z != '0);
                end
            end
            tass_pkg::KIND_ESTOP: begin
                if (r_active) begin
                    n_abort = 1'b1;
                end
                n_active = 1'b0;
                n_enable = 1'b0;
            end
            tass_pkg::KIND_TICK: begin
                if (r_active) begin
                    if (r_wait != '0) begin
                        n_wait = r_wait - DB'(1);
                    end else if (ax == tass_pkg::AXIS_NONE) begin
                        n_active = 1'b0;
                    end else if (i_item.endstop_mask[ax]) begin
                        n_active = 1'b0;
                        n_abort  = 1'b1;
                    end else begin
                        pulse[ax] = 1'b1;
                        for (int a = 0; a < NA; a++) begin
                            if (AW'(a) == ax) begin
                                n_pos[a] = ax_pos_step;
                            end
                        end
                        n_wait = (ax_delay == '0) ? '0 : ax_delay - DB'(1);
                        if (ax == tass_pkg::AXIS_Z) begin
                            n_phase = tass_pkg::AXIS_X;
                            n_round = SB'(round_use + {{SB{1'b0}}, 1'b1});
                        end else begin
                            n_phase = ax + AW'(1);
                            n_round = round_use[SB-1:0];
                        end
                    end
                end
            end
            default: begin
                // unused kind: hold
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_round  <= '0;
            r_phase  <= tass_pkg::AXIS_X;
            r_wait   <= '0;
            r_dir    <= '0;
            r_abort  <= 1'b0;
            r_enable <= 1'b1;
            for (int a = 0; a < NA; a++) begin
                r_counts[a] <= '0;
                r_delays[a] <= '0;
                r_pos[a]    <= '0;
            end
        end else if (i_fire) begin
            r_active <= n_active;
            r_round  <= n_round;
            r_phase  <= n_phase;
            r_wait   <= n_wait;
            r_dir    <= n_dir;
            r_abort  <= n_abort;
            r_enable <= n_enable;
            for (int a = 0; a < NA; a++) begin
                r_counts[a] <= n_counts[a];
                r_delays[a] <= n_delays[a];
                r_pos[a]    <= n_pos[a];
            end
        end
    end

    always_comb begin
        o_result.step_mask = pulse;
        o_result.dir_out   = n_dir;
        o_result.busy_res  = n_active;
        o_result.aborted   = n_abort;
        o_result.enabled   = n_enable;
        o_result.pos_x     = n_pos[0];
        o_result.pos_y     = n_pos[1];
        o_result.pos_z     = n_pos[2];
    end

endmodule
`default_nettype wire

FILE: sv/three_axis_step_sequencer.sv
// An item passes the input register, then the core and the result register.
// Throughput: one item per cycle unless the result side stalls.
// Both registers advance while the result side takes or the result register is empty.
// Reset (synchronous, active low): idle, positions and counts zero, enable set,
// both register stages empty, input not ready.
// Top level: input register, state update core and result register.
// Depends on tass_pkg, tass_in_if, tass_out_if and tass_core.
`default_nettype none
module three_axis_step_sequencer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tass_in_if.sink     i_in,
    tass_out_if.source  o_out
);

    logic                r_in_valid;
    tass_pkg::t_in_item  r_in;
    logic                r_out_valid;
    tass_pkg::t_out_item r_out;
    tass_pkg::t_out_item core_result;
    logic                out_free;
    logic                fire;

    assign out_free   = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && out_free;
    assign i_in.ready = i_rst_n && (!r_in_valid || out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    tass_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for three_axis_step_sequencer: a directed table, then random moves,
// all results checked in order against hand-written words or a behavioral predictor of the sequencer.
// Depends on tass_pkg, tass_in_if, tass_out_if and the RTL of the block.
`timescale 1ns / 100ps

module testbench;
    import tass_pkg::*;

    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 500;
    localparam int MAX_PRINTS   = 20;

    typedef struct packed {
        logic      checked;
        t_out_item want;
        t_in_item  item;
    } t_plan_row;

    localparam t_out_item FROM_PREDICTOR = '0;

    logic i_clk;
    logic i_rst_n;

    tass_in_if  in_ch();
    tass_out_if out_ch();

    three_axis_step_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predicted sequencer state
    logic                     moving;
    logic [STEP_COUNT_BITS:0] round_no;
    logic [AXIS_W-1:0]        next_axis;
    t_delay                   hold_ticks;
    t_count                   move_steps [NUM_AXES];
    t_delay                   move_delay [NUM_AXES];
    logic [NUM_AXES-1:0]      latched_dir;
    t_pos                     axis_pos [NUM_AXES];
    logic                     abort_seen;
    logic                     drive_enable;

    t_out_item expected_results[$];
    t_in_item  pending_items[$];

    int cycles       = 0;
    int failures     = 0;
    int items_sent   = 0;
    int random_sent  = 0;
    int results_seen = 0;
    int pulses_seen  = 0;

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycles <= cycles + 1;

    // First axis at or after 'from' whose step count exceeds the round, else AXIS_NONE
    function automatic logic [AXIS_W-1:0] first_due(logic [AXIS_W-1:0] from,
                                                     logic [STEP_COUNT_BITS:0] rnd);
        for (int a = 0; a < NUM_AXES; a++) begin
            if (a >= from && {1'b0, move_steps[a]} > rnd) return a[AXIS_W-1:0];
        end
        return AXIS_NONE;
    endfunction

    function automatic t_out_item predict_move(t_in_item it);
        t_out_item                r;
        logic [NUM_AXES-1:0]      pulse;
        logic [AXIS_W-1:0]        ax;
        logic [STEP_COUNT_BITS:0] rnd;
        pulse = '0;
        case (t_kind'(it.kind))
            KIND_START: begin
                if (!moving) begin
                    move_steps[0] = it.steps_x;
                    move_steps[1] = it.steps_y;
                    move_steps[2] = it.steps_z;
                    move_delay[0] = it.delay_x;
                    move_delay[1] = it.delay_y;
                    move_delay[2] = it.delay_z;
                    latched_dir   = it.dir_mask;
                    round_no      = '0;
                    next_axis     = AXIS_X;
                    hold_ticks    = '0;
                    abort_seen    = 1'b0;
                    moving        = first_due(AXIS_X, '0) != AXIS_NONE;
                end
            end
            KIND_ESTOP: begin
                if (moving) abort_seen = 1'b1;
                moving       = 1'b0;
                drive_enable = 1'b0;
            end
            KIND_TICK: begin
                if (moving) begin
                    if (hold_ticks != 0) begin
                        hold_ticks = hold_ticks - 1'b1;
                    end else begin
                        rnd = round_no;
                        ax  = first_due(next_axis, rnd);
                        // nothing left in this round: move on to the next one
                        if (ax == AXIS_NONE) begin
                            rnd = rnd + 1'b1;
                            ax  = first_due(AXIS_X, rnd);
                        end
                        if (ax == AXIS_NONE) begin
                            moving = 1'b0;
                        end else if (it.endstop_mask[ax]) begin
                            moving     = 1'b0;
                            abort_seen = 1'b1;
                        end else begin
                            pulse[ax]    = 1'b1;
                            axis_pos[ax] = latched_dir[ax] ? axis_pos[ax] + 1'b1
                                                           : axis_pos[ax] - 1'b1;
                            hold_ticks   = (move_delay[ax] == 0) ? 0 : move_delay[ax] - 1'b1;
                            if (ax == AXIS_Z) begin
                                next_axis = AXIS_X;
                                round_no  = (rnd + 1'b1) & {1'b0, {STEP_COUNT_BITS{1'b1}}};
                            end else begin
                                next_axis = ax + 1'b1;
                                round_no  = rnd;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.step_mask = pulse;
        r.dir_out   = latched_dir;
        r.busy_res  = moving;
        r.aborted   = abort_seen;
        r.enabled   = drive_enable;
        r.pos_x     = axis_pos[0];
        r.pos_y     = axis_pos[1];
        r.pos_z     = axis_pos[2];
        return r;
    endfunction

    function automatic t_in_item make_item(t_kind k, t_count sx, t_count sy, t_count sz,
                                           logic [2:0] dir, t_delay dx, t_delay dy,
                                           t_delay dz, logic [2:0] es);
        t_in_item it;
        it.kind         = k;
        it.steps_x      = sx;
        it.steps_y      = sy;
        it.steps_z      = sz;
        it.dir_mask     = dir;
        it.delay_x      = dx;
        it.delay_y      = dy;
        it.delay_z      = dz;
        it.endstop_mask = es;
        return it;
    endfunction

    function automatic t_out_item status_word(logic [2:0] step, logic [2:0] dir, logic busy,
                                              logic ab, logic en, int px, int py, int pz);
        t_out_item r;
        r.step_mask = step;
        r.dir_out   = dir;
        r.busy_res  = busy;
        r.aborted   = ab;
        r.enabled   = en;
        r.pos_x     = px;
        r.pos_y     = py;
        r.pos_z     = pz;
        return r;
    endfunction

    function automatic t_in_item random_item(t_kind k);
        logic [127:0] raw;
        t_in_item     it;
        raw     = {$urandom, $urandom, $urandom, $urandom};
        it      = raw[$bits(t_in_item)-1:0];
        it.kind = k;
        return it;
    endfunction

    // Append one random move (or a burst of noise) to the pending items
    task automatic queue_random_sequence();
        t_in_item it;
        int       style;
        int       ticks;
        style = $urandom_range(0, 9);
        if (style == 8) begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 9))
                    0:       it = random_item(KIND_ESTOP);
                    1, 2:    it = random_item(KIND_NOP);
                    3: begin
                        it         = random_item(KIND_START);
                        it.steps_x = '0;
                        it.steps_y = '0;
                        it.steps_z = '0;
                    end
                    default: it = random_item(KIND_TICK);
                endcase
                pending_items.push_back(it);
            end
        end else begin
            it = random_item(KIND_START);
            if (style == 7) begin
                // full-range move, ended by an emergency stop below
                ticks = $urandom_range(5, 30);
            end else if (style == 9) begin
                it.steps_x = $urandom_range(0, 40);
                it.steps_y = $urandom_range(0, 40);
                it.steps_z = $urandom_range(0, 40);
                it.delay_x = $urandom_range(0, 2);
                it.delay_y = $urandom_range(0, 2);
                it.delay_z = $urandom_range(0, 2);
                ticks      = $urandom_range(0, 150);
            end else begin
                it.steps_x = $urandom_range(0, 4);
                it.steps_y = $urandom_range(0, 4);
                it.steps_z = $urandom_range(0, 4);
                it.delay_x = $urandom_range(0, 3);
                it.delay_y = $urandom_range(0, 3);
                it.delay_z = $urandom_range(0, 3);
                ticks      = $urandom_range(0, 50);
            end
            pending_items.push_back(it);
            // a second start lands while the move runs and must be dropped
            if (style != 7 && (it.steps_x | it.steps_y | it.steps_z) != 0
                    && $urandom_range(0, 3) == 0)
                pending_items.push_back(random_item(KIND_START));
            repeat (ticks) begin
                it = random_item(KIND_TICK);
                if (style != 7)
                    it.endstop_mask = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 7) : 0;
                pending_items.push_back(it);
            end
            if (style == 7) pending_items.push_back(random_item(KIND_ESTOP));
        end
    endtask

    // Offer one item, wait for the transfer, then record what it must produce
    task automatic offer_item(input t_in_item it, input logic checked, input t_out_item want);
        int        gap;
        t_out_item predicted;
        gap = (items_sent % 250 < 60) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = predict_move(it);
        expected_results.push_back(checked ? want : predicted);
        items_sent++;
    endtask

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= MAX_PRINTS) $display("ERROR cycle %0d: %s", cycles, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_failure($sformatf("%s got %h expected %h", name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_failure("result transfer with nothing expected");
            end else begin
                want = expected_results.pop_front();
                check_field("step_mask", out_ch.data.step_mask, want.step_mask);
                check_field("dir_out",   out_ch.data.dir_out,   want.dir_out);
                check_field("busy_res",  out_ch.data.busy_res,  want.busy_res);
                check_field("aborted",   out_ch.data.aborted,   want.aborted);
                check_field("enabled",   out_ch.data.enabled,   want.enabled);
                check_field("pos_x",     out_ch.data.pos_x,     want.pos_x);
                check_field("pos_y",     out_ch.data.pos_y,     want.pos_y);
                check_field("pos_z",     out_ch.data.pos_z,     want.pos_z);
            end
            results_seen++;
            if (out_ch.data.step_mask != 0) pulses_seen++;
        end
    end

    initial begin : result_sink
        int   gap;
        logic held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            // one long hold so the block fills up and back-pressures the input
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end else begin
                gap = (results_seen % 230 < 50) ? 0 : $urandom_range(0, 19);
            end
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("TIMEOUT after %0d cycles, %0d results outstanding",
                 cycles, expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        t_plan_row plan[$];
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;

        moving       = 1'b0;
        round_no     = '0;
        next_axis    = AXIS_X;
        hold_ticks   = '0;
        latched_dir  = '0;
        abort_seen   = 1'b0;
        drive_enable = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            move_steps[a] = '0;
            move_delay[a] = '0;
            axis_pos[a]   = '0;
        end

        // idle tick and ignored kind with every field at its maximum
        plan.push_back({1'b1, status_word(3'b000, 3'b000, 0, 0, 1, 0, 0, 0),
            make_item(KIND_TICK, '1, '1, '1, 3'b111, '1, '1, '1, 3'b111)});
        plan.push_back({1'b1, status_word(3'b000, 3'b000, 0, 0, 1, 0, 0, 0),
            make_item(KIND_NOP, '1, '1, '1, 3'b111, '1, '1, '1, 3'b111)});
        // all counts zero: done at once, directions still latched
        plan.push_back({1'b1, status_word(3'b000, 3'b111, 0, 0, 1, 0, 0, 0),
            make_item(KIND_START, 0, 0, 0, 3'b111, '1, '1, '1, 3'b000)});
        // one step per axis, X and Z positive, Y negative
        plan.push_back({1'b1, status_word(3'b000, 3'b101, 1, 0, 1, 0, 0, 0),
            make_item(KIND_START, 1, 1, 1, 3'b101, 0, 0, 0, 3'b000)});
        plan.push_back({1'b1, status_word(3'b001, 3'b101, 1, 0, 1, 1, 0, 0),
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        plan.push_back({1'b1, status_word(3'b010, 3'b101, 1, 0, 1, 1, -1, 0),
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        plan.push_back({1'b1, status_word(3'b100, 3'b101, 1, 0, 1, 1, -1, 1),
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        plan.push_back({1'b1, status_word(3'b000, 3'b101, 0, 0, 1, 1, -1, 1),
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        // spaced X steps, a start while busy, endstop while waiting then while due
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_START, 2, 0, 0, 3'b000, 2, 0, 0, 3'b000)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_START, '1, '1, '1, 3'b111, '1, '1, '1, 3'b111)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b001)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b001)});
        // largest move with longest spacing, cut short by emergency stop
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_START, '1, '1, '1, 3'b111, '1, '1, '1, 3'b000)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b111)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_ESTOP, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_ESTOP, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        // move while disabled: Z only, two rounds
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_START, 0, 0, 2, 3'b000, 0, 0, 1, 3'b000)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b000)});
        // Y endstop aborts, then an empty start clears the abort
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_START, 0, 1, 0, 3'b010, 0, 0, 0, 3'b000)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_TICK, 0, 0, 0, 3'b000, 0, 0, 0, 3'b110)});
        plan.push_back({1'b0, FROM_PREDICTOR,
            make_item(KIND_START, 0, 0, 0, 3'b011, 0, 0, 0, 3'b000)});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) offer_item(plan[i].item, plan[i].checked, plan[i].want);

        while (random_sent < RANDOM_ITEMS) begin
            if (pending_items.size() == 0) queue_random_sequence();
            offer_item(pending_items.pop_front(), 1'b0, FROM_PREDICTOR);
            random_sent++;
        end
        in_ch.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run: %0d directed and %0d random items, %0d results checked in %0d cycles",
                 plan.size(), random_sent, results_seen, cycles);
        $display("Step pulses observed: %0d, mismatches: %0d", pulses_seen, failures);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/tass_pkg.sv
sv/tass_in_if.sv
sv/tass_out_if.sv
sv/tass_core.sv
sv/three_axis_step_sequencer.sv
tb/testbench.sv
